### sv/pah_pkg.sv
// ----------------------------------------------------------------------------
// pah_pkg
// Shared constants, types and the CORDIC angle table for the polar angle
// histogram block.
// ----------------------------------------------------------------------------
package pah_pkg;

	localparam int NUM_BINS     = 360;
	localparam int MID_BIN      = 90;
	localparam int COORD_BITS   = 11;
	localparam int COUNT_BITS   = 22;
	localparam int CORDIC_STEPS = 16;

	localparam int PX_W    = 11;
	localparam int VP_W    = 13;
	localparam int BIN_W   = 9;
	localparam int START_W = 7;
	localparam int END_W   = 9;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 9;

	// Difference of a coordinate and the vanishing point, signed.
	localparam int DIFF_W = ((COORD_BITS > VP_W) ? COORD_BITS : VP_W) + 2;
	// 24 fraction bits plus headroom for the CORDIC gain.
	localparam int FRAC_W = 24;
	localparam int CW     = DIFF_W + 3 + FRAC_W;
	localparam int STEP_W = $clog2(CORDIC_STEPS);

	localparam logic [PX_W-1:0]       PX_MASK   = PX_W'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [CIDX_W-1:0] REG_RANGE_START = 2'd0;
	localparam logic [CIDX_W-1:0] REG_RANGE_END   = 2'd1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [BIN_W-1:0]      bin_t;

	// atan(2^-i) in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

### sv/pah_if.sv
// ----------------------------------------------------------------------------
// pah channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface pah_pix_if;
	import pah_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [7:0]             pixel;
	logic [PX_W-1:0]        px;
	logic [PX_W-1:0]        py;
	logic signed [VP_W-1:0] vp_x;
	logic signed [VP_W-1:0] vp_y;
	logic                   last_pixel;
	modport source(output valid, pixel, px, py, vp_x, vp_y, last_pixel, input ready);
	modport sink(input valid, pixel, px, py, vp_x, vp_y, last_pixel, output ready);
endinterface

interface pah_res_if;
	import pah_pkg::*;
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] left_bin;
	logic [BIN_W-1:0] right_bin;
	logic             left_valid;
	logic             right_valid;
	logic             found;
	modport source(output valid, left_bin, right_bin, left_valid, right_valid, found,
		input ready);
	modport sink(input valid, left_bin, right_bin, left_valid, right_valid, found,
		output ready);
endinterface

interface pah_cfg_if;
	import pah_pkg::*;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### sv/pah_cordic.sv
// ----------------------------------------------------------------------------
// pah_cordic
// Iterative vectoring CORDIC: one rotation per cycle, then the angle is
// scaled to a one-degree bin.
// ----------------------------------------------------------------------------
module pah_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [pah_pkg::DIFF_W-1:0] dx,
	input  logic signed [pah_pkg::DIFF_W-1:0] dy,
	output logic                              done,
	output pah_pkg::bin_t                     bin
);
	import pah_pkg::*;

	logic              busy_q, mul_q, done_q, zero_q;
	logic [STEP_W-1:0] step_q;
	logic signed [CW-1:0] x_q, y_q, xs, ys, x0, y0;
	logic [31:0]       z_q;
	logic [15+BIN_W:0] prod;
	bin_t              bin_q;

	assign x0 = CW'(dx) <<< FRAC_W;
	assign y0 = CW'(dy) <<< FRAC_W;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign prod = (BIN_W+16)'(z_q[31:16]) * (BIN_W+16)'(NUM_BINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && !busy_q && mul_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					mul_q  <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end else if (mul_q) begin
				mul_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == '0) && (dy == '0);
			// Left half plane: turn by half a turn first.
			if (dx < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= 32'h80000000;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_turn(5'(step_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_turn(5'(step_q));
			end
		end else if (mul_q) begin
			bin_q <= zero_q ? '0 : prod[15+BIN_W:16];
		end
	end

	assign done = done_q;
	assign bin  = bin_q;

endmodule

### sv/polar_angle_histogram_peaks.sv
// ----------------------------------------------------------------------------
// polar_angle_histogram_peaks
// Edge pixel angle histogram around a vanishing point with windowed peak
// search at the end of each frame.
// ----------------------------------------------------------------------------
// A zero pixel word leaves the histogram as it is. An edge pixel takes 16
// CORDIC rotations in one shared unit, the angle scaled to a bin, and a
// read-modify-write of the 360-entry histogram memory through its single read
// and write port. The word that ends a frame adds a scan of the memory, which
// also clears each bin behind the read, and a step to post the result word;
// that step waits while an earlier result word is still unaccepted. After
// reset the block takes no pixel words while it clears the histogram; the
// configuration channel is always ready.
module polar_angle_histogram_peaks (
	input  logic       clk,
	input  logic       arst_n,
	pah_cfg_if.sink    cfg,
	pah_pix_if.sink    pix,
	pah_res_if.source  res
);
	import pah_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_CORD = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]         st_q;
	logic [BIN_W-1:0]   scan_q;
	logic               last_q;
	logic [START_W-1:0] start_q;
	logic [END_W-1:0]   end_q;
	count_t             edges_q;
	count_t             hist_mem [NUM_BINS];
	count_t             rdata_q;
	bin_t               raddr, waddr, bin_q, addr_s1;
	count_t             wdata;
	logic               we, rd_s1;
	logic               accept, edge_px, cord_start, cord_done;
	bin_t               cord_bin;
	logic signed [DIFF_W-1:0] dx, dy;
	bin_t               lbest_q, rbest_q;
	count_t             lmax_q, rmax_q;
	logic               in_l, in_r, lval, rval;
	logic [END_W-1:0]   hi;

	assign cfg.ready = 1'b1;
	assign pix.ready = (st_q == S_IDLE);
	assign accept    = pix.valid && pix.ready;
	assign edge_px   = (pix.pixel != 8'd0);
	assign cord_start = accept && edge_px;

	assign dx = $signed({{(DIFF_W-PX_W){1'b0}}, pix.px & PX_MASK})
		- $signed({{(DIFF_W-VP_W){pix.vp_x[VP_W-1]}}, pix.vp_x});
	assign dy = $signed({{(DIFF_W-PX_W){1'b0}}, pix.py & PX_MASK})
		- $signed({{(DIFF_W-VP_W){pix.vp_y[VP_W-1]}}, pix.vp_y});

	pah_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.dx     (dx),
		.dy     (dy),
		.done   (cord_done),
		.bin    (cord_bin)
	);

	// Right window end is clipped to the histogram.
	assign hi   = (end_q > END_W'(NUM_BINS)) ? END_W'(NUM_BINS) : end_q;
	assign lval = (START_W'(MID_BIN) > start_q);
	assign rval = (hi > END_W'(MID_BIN));
	assign in_l = (addr_s1 >= BIN_W'(start_q)) && (addr_s1 < BIN_W'(MID_BIN));
	assign in_r = (addr_s1 >= BIN_W'(MID_BIN)) && (addr_s1 < BIN_W'(hi));

	always_comb begin
		raddr = (st_q == S_CORD) ? cord_bin : scan_q;
		we    = 1'b0;
		waddr = scan_q;
		wdata = '0;
		case (st_q)
			S_CLR: begin
				we = 1'b1;
			end
			S_WR: begin
				we    = 1'b1;
				waddr = bin_q;
				wdata = (rdata_q == COUNT_MAX) ? rdata_q : rdata_q + 1'b1;
			end
			S_SCAN: begin
				we    = rd_s1;
				waddr = addr_s1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			hist_mem[waddr] <= wdata;
		end
		rdata_q <= hist_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			scan_q      <= '0;
			last_q      <= 1'b0;
			start_q     <= '0;
			end_q       <= END_W'(NUM_BINS);
			edges_q     <= '0;
			rd_s1       <= 1'b0;
			res.valid   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_RANGE_START) begin
					start_q <= cfg.data[START_W-1:0];
				end else if (cfg.index == REG_RANGE_END) begin
					end_q <= cfg.data[END_W-1:0];
				end
			end
			if (res.valid && res.ready && st_q != S_DONE) begin
				res.valid <= 1'b0;
			end
			rd_s1 <= (st_q == S_SCAN) && (scan_q != BIN_W'(NUM_BINS));
			case (st_q)
				S_CLR: begin
					if (scan_q == BIN_W'(NUM_BINS - 1)) begin
						scan_q <= '0;
						st_q   <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						last_q <= pix.last_pixel;
						scan_q <= '0;
						if (edge_px) begin
							if (edges_q != COUNT_MAX) begin
								edges_q <= edges_q + 1'b1;
							end
							st_q <= S_CORD;
						end else if (pix.last_pixel) begin
							st_q <= S_SCAN;
						end
					end
				end
				S_CORD: begin
					if (cord_done) begin
						bin_q <= cord_bin;
						st_q  <= S_WR;
					end
				end
				S_WR: begin
					st_q <= last_q ? S_SCAN : S_IDLE;
				end
				S_SCAN: begin
					if (scan_q == BIN_W'(NUM_BINS)) begin
						st_q <= S_DONE;
					end else begin
						addr_s1 <= scan_q;
						scan_q  <= scan_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!res.valid || res.ready) begin
						res.valid       <= 1'b1;
						res.left_bin    <= lval ? lbest_q : '0;
						res.right_bin   <= rval ? rbest_q : '0;
						res.left_valid  <= lval;
						res.right_valid <= rval;
						res.found       <= (edges_q != '0);
						edges_q         <= '0;
						scan_q          <= '0;
						st_q            <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Peak trackers: the first bin of a window seeds it, later bins replace
	// it only when strictly larger.
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			if (in_l && (addr_s1 == BIN_W'(start_q) || rdata_q > lmax_q)) begin
				lbest_q <= addr_s1;
				lmax_q  <= rdata_q;
			end
			if (in_r && (addr_s1 == BIN_W'(MID_BIN) || rdata_q > rmax_q)) begin
				rbest_q <= addr_s1;
				rmax_q  <= rdata_q;
			end
		end
	end

	a_wr_after_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_WR |-> $past(st_q) == S_CORD && $past(cord_done))
		else $error("histogram write without a finished angle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= BIN_W'(NUM_BINS))
		else $error("scan counter beyond histogram");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> st_q == S_SCAN)
		else $error("scan read data outside the scan");

	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> st_q == S_CORD)
		else $error("angle finished while not waiting for it");

endmodule
